// ===== src/cpr_pkg.sv =====
// ============================================================================
// cpr_pkg
// Shared types, codes and the CRC-8 step of the controller pak responder.
// ============================================================================
package cpr_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_WRITE  = 2'd3;

    // configuration register indexes
    localparam logic REG_PRESENT_MASK = 1'b0;
    localparam logic REG_PAK_MASK     = 1'b1;

    // block geometry
    localparam int BLOCK_BYTES = 32;
    localparam int BLK_AW      = $clog2(BLOCK_BYTES);
    localparam int CNT_W       = BLK_AW + 1;
    localparam int CALC_W      = 18;

    // bus widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // fixed values
    localparam logic [7:0]  CRC_POLY     = 8'h85;
    localparam logic [15:0] SPECIAL_ADDR = 16'h8001;
    localparam logic [15:0] ALIGN_MASK   = 16'hFFE0;
    localparam logic [7:0]  ID_BYTE      = 8'h05;

    // output load selector
    localparam logic [2:0] LD_NODEV  = 3'd0;
    localparam logic [2:0] LD_STATUS = 3'd1;
    localparam logic [2:0] LD_ID0    = 3'd2;
    localparam logic [2:0] LD_ID1    = 3'd3;
    localparam logic [2:0] LD_ID2    = 3'd4;
    localparam logic [2:0] LD_DATA   = 3'd5;
    localparam logic [2:0] LD_CRC    = 3'd6;
    localparam logic [2:0] LD_WFIN   = 3'd7;

    typedef struct packed {
        logic              accept;
        logic              ld;
        logic [2:0]        ld_kind;
        logic              rd_issue;
        logic [BLK_AW-1:0] rd_idx;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       no_reply;
        logic       wlast;
        logic       present;
        logic       out_free;
    } sts_t;

    // shift one byte, msb first, through the CRC register
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc;
        d = data;
        for (int b = 0; b < 8; b++)
        begin
            fb = c[7];
            c  = {c[6:0], d[7]};
            d  = {d[6:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/cpr_datapath.sv =====
// ============================================================================
// cpr_datapath
// Config registers, pak memory, CRC register, item latch and output register.
// ============================================================================
module cpr_datapath #(
    parameter int PAK_BYTES = 32768,
    parameter int PORTS     = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [3:0]                     cfg_data,
    input  logic [cpr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           s_tlast,
    input  cpr_pkg::cmd_t                  cmd,
    output cpr_pkg::sts_t                  sts,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [cpr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int MEM_DEPTH = PORTS * PAK_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    logic [7:0] mem [MEM_DEPTH];

    logic [3:0] present_mask_reg;
    logic [3:0] pak_mask_reg;

    logic [7:0]                 crc_reg, crc_next;
    logic [cpr_pkg::BLK_AW-1:0] wr_idx_reg, wr_idx_next;

    logic              present_reg, pak_reg, special_reg, in_range_reg;
    logic [MEM_AW-1:0] base_reg;
    logic [7:0]        rd_data_reg;

    logic       m_valid_reg;
    logic       nodev_reg, crc_flag_reg, last_reg;
    logic [7:0] byte_reg;

    // current item fields
    logic [1:0]  port;
    logic        no_reply;
    logic [15:0] pak_address;
    logic [7:0]  write_byte;
    logic [15:0] aligned;
    logic        present_now, pak_now, special_now, in_range_now, use_now;
    logic [cpr_pkg::CALC_W-1:0] base_full;
    logic [MEM_AW-1:0] base_now;
    logic        out_free;
    logic [7:0]  data_byte, crc_fin;
    logic        ld_nodev, ld_flag, ld_last;
    logic [7:0]  ld_byte;

    assign port        = s_tdata[1:0];
    assign no_reply    = s_tdata[2];
    assign pak_address = s_tdata[18:3];
    assign write_byte  = s_tdata[26:19];

    assign aligned      = pak_address & cpr_pkg::ALIGN_MASK;
    assign present_now  = ({1'b0, port} < 3'(PORTS)) && present_mask_reg[port];
    assign pak_now      = present_now && pak_mask_reg[port];
    assign special_now  = (pak_address == cpr_pkg::SPECIAL_ADDR);
    assign in_range_now = ({1'b0, aligned} + 17'(cpr_pkg::BLOCK_BYTES)) <= 17'(PAK_BYTES);
    assign use_now      = pak_now && !special_now && in_range_now;
    assign base_full    = cpr_pkg::CALC_W'(port) * cpr_pkg::CALC_W'(PAK_BYTES)
                        + cpr_pkg::CALC_W'(aligned);
    assign base_now     = base_full[MEM_AW-1:0];

    assign out_free = !m_valid_reg || m_tready;

    assign sts.op       = s_tuser;
    assign sts.no_reply = no_reply;
    assign sts.wlast    = s_tlast;
    assign sts.present  = present_now;
    assign sts.out_free = out_free;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_mask_reg <= 4'd0;
            pak_mask_reg     <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpr_pkg::REG_PAK_MASK:
                begin
                    pak_mask_reg <= cfg_data;
                end
                cpr_pkg::REG_PRESENT_MASK:
                begin
                    present_mask_reg <= cfg_data;
                end
            endcase
        end
    end

    // pak memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && s_tuser == cpr_pkg::OP_WRITE && use_now)
        begin
            mem[base_now + MEM_AW'(wr_idx_reg)] <= write_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[base_reg + MEM_AW'(cmd.rd_idx)];
        end
    end

    // latch item flags for the later results of a command
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            present_reg  <= present_now;
            pak_reg      <= pak_now;
            special_reg  <= special_now;
            in_range_reg <= in_range_now;
            base_reg     <= base_now;
        end
    end

    assign data_byte = (pak_reg && !special_reg && in_range_reg) ? rd_data_reg : 8'h00;
    assign crc_fin   = cpr_pkg::crc_feed(crc_reg, 8'h00);

    always_comb
    begin
        crc_next    = crc_reg;
        wr_idx_next = wr_idx_reg;
        priority if (cmd.accept && s_tuser == cpr_pkg::OP_WRITE)
        begin
            crc_next    = cpr_pkg::crc_feed(crc_reg, write_byte);
            wr_idx_next = s_tlast ? '0 : wr_idx_reg + 1'b1;
        end
        else if (cmd.accept)
        begin
            crc_next    = 8'h00;
            wr_idx_next = '0;
        end
        else if (cmd.ld && cmd.ld_kind == cpr_pkg::LD_DATA)
        begin
            crc_next = cpr_pkg::crc_feed(crc_reg, data_byte);
        end
        else if (cmd.ld && (cmd.ld_kind == cpr_pkg::LD_CRC || cmd.ld_kind == cpr_pkg::LD_WFIN))
        begin
            crc_next = 8'h00;
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= 8'h00;
            wr_idx_reg <= '0;
        end
        else
        begin
            crc_reg    <= crc_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    // output value for each load kind
    always_comb
    begin
        ld_nodev = 1'b0;
        ld_byte  = 8'h00;
        ld_flag  = 1'b0;
        ld_last  = 1'b1;
        unique case (cmd.ld_kind)
            cpr_pkg::LD_NODEV:
            begin
                ld_nodev = 1'b1;
            end
            cpr_pkg::LD_STATUS:
            begin
                ld_nodev = !present_now;
            end
            cpr_pkg::LD_ID0:
            begin
                ld_byte = cpr_pkg::ID_BYTE;
                ld_last = 1'b0;
            end
            cpr_pkg::LD_ID1:
            begin
                ld_last = 1'b0;
            end
            cpr_pkg::LD_ID2:
            begin
                ld_byte = {7'd0, pak_reg};
            end
            cpr_pkg::LD_DATA:
            begin
                ld_byte = data_byte;
                ld_last = 1'b0;
            end
            cpr_pkg::LD_CRC:
            begin
                ld_byte = crc_fin;
                ld_flag = 1'b1;
            end
            cpr_pkg::LD_WFIN:
            begin
                priority if (!present_reg)
                begin
                    ld_nodev = 1'b1;
                end
                else if (pak_reg && !special_reg && !in_range_reg)
                begin
                    ld_byte = 8'h00;
                end
                else
                begin
                    ld_byte = crc_fin;
                    ld_flag = 1'b1;
                end
            end
            default:
            begin
                ld_nodev = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.ld)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld)
        begin
            nodev_reg    <= ld_nodev;
            byte_reg     <= ld_byte;
            crc_flag_reg <= ld_flag;
            last_reg     <= ld_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, crc_flag_reg, byte_reg, nodev_reg};
    assign m_tuser  = crc_flag_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/cpr_ctrl.sv =====
// ============================================================================
// cpr_ctrl
// Command sequencer: accepts items, steps check, read and write-finish runs.
// ============================================================================
module cpr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  cpr_pkg::sts_t sts,
    output cpr_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK1 = 3'd1;
    localparam logic [2:0] S_CHK2 = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [cpr_pkg::CNT_W-1:0] CNT_END = cpr_pkg::CNT_W'(cpr_pkg::BLOCK_BYTES);

    logic [2:0]                state_reg, state_next;
    logic [cpr_pkg::CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [cpr_pkg::CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                      rdv_reg, rdv_next;
    logic                      accept, ld_data, issue;

    assign s_tready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;
    assign ld_data  = (state_reg == S_READ) && rdv_reg && sts.out_free;
    assign issue    = (state_reg == S_READ) && (rd_cnt_reg != CNT_END) && (!rdv_reg || ld_data);

    always_comb
    begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        out_cnt_next = out_cnt_reg;
        rdv_next     = rdv_reg;
        cmd.accept   = accept;
        cmd.ld       = 1'b0;
        cmd.ld_kind  = cpr_pkg::LD_NODEV;
        cmd.rd_issue = issue;
        cmd.rd_idx   = rd_cnt_reg[cpr_pkg::BLK_AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (sts.op)
                        cpr_pkg::OP_CHECK:
                        begin
                            if (!sts.no_reply)
                            begin
                                cmd.ld = 1'b1;
                                if (sts.present)
                                begin
                                    cmd.ld_kind = cpr_pkg::LD_ID0;
                                    state_next  = S_CHK1;
                                end
                            end
                        end
                        cpr_pkg::OP_STATUS:
                        begin
                            cmd.ld      = 1'b1;
                            cmd.ld_kind = cpr_pkg::LD_STATUS;
                        end
                        cpr_pkg::OP_READ:
                        begin
                            if (sts.present)
                            begin
                                state_next   = S_READ;
                                rd_cnt_next  = '0;
                                out_cnt_next = '0;
                                rdv_next     = 1'b0;
                            end
                            else
                            begin
                                cmd.ld = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (sts.wlast)
                            begin
                                state_next = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_CHK1:
            begin
                if (sts.out_free)
                begin
                    cmd.ld      = 1'b1;
                    cmd.ld_kind = cpr_pkg::LD_ID1;
                    state_next  = S_CHK2;
                end
            end
            S_CHK2:
            begin
                if (sts.out_free)
                begin
                    cmd.ld      = 1'b1;
                    cmd.ld_kind = cpr_pkg::LD_ID2;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
            begin
                // one-deep prefetch: refill the read register as its byte leaves
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    rdv_next    = 1'b1;
                end
                else if (ld_data)
                begin
                    rdv_next = 1'b0;
                end
                if (ld_data)
                begin
                    cmd.ld       = 1'b1;
                    cmd.ld_kind  = cpr_pkg::LD_DATA;
                    out_cnt_next = out_cnt_reg + 1'b1;
                end
                else if (out_cnt_reg == CNT_END && sts.out_free)
                begin
                    cmd.ld      = 1'b1;
                    cmd.ld_kind = cpr_pkg::LD_CRC;
                    state_next  = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.ld      = 1'b1;
                    cmd.ld_kind = cpr_pkg::LD_WFIN;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            rdv_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            out_cnt_reg <= out_cnt_next;
            rdv_reg     <= rdv_next;
        end
    end

    // a load never overwrites a result that is still waiting
    a_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld |-> sts.out_free)
        else $error("output register overwritten");

    // reads are issued only inside a read run and never past the block
    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (state_reg == S_READ && rd_cnt_reg != CNT_END))
        else $error("read issued outside block");

    // bytes leave no faster than they are fetched
    a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (out_cnt_reg + cpr_pkg::CNT_W'(rdv_reg) == rd_cnt_reg))
        else $error("read counters out of step");

    // the CRC load ends the read run
    a_crc_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ld && cmd.ld_kind == cpr_pkg::LD_CRC) |=> (state_reg == S_IDLE))
        else $error("read run did not end after CRC");

endmodule

// ===== src/controller_pak_responder.sv =====
// ============================================================================
// controller_pak_responder
// Answers check, status, pak read and pak write commands for controller ports.
// ============================================================================
// Usage:
//   Commands enter on the s_* stream (s_tuser = op, s_tlast = last write byte),
//   results leave on the m_* stream (m_tuser = CRC byte, m_tlast = last result
//   of the command). present_mask and pak_mask are written on cfg_* while idle.
// Timing and throughput:
//   Check and status results appear in the cycle after acceptance; a check of
//   a present port emits its three bytes in turn as the output register frees.
//   A pak read emits its 32 data bytes and CRC one per cycle while the receiver
//   is ready, after the first memory fetch, bound by the single registered read
//   port of the pak memory. Write bytes are accepted one per cycle while the
//   output is free; after a block's last byte a finish step loads the result.
// Reset:
//   Clears the masks, CRC and write index; pak memory contents are undefined
//   until written, and no clearing pass runs.
// Stall:
//   A result waits in the output register; commands are taken only while
//   that register is free or being emptied, so a stalled receiver holds input.
// ============================================================================
module controller_pak_responder #(
    parameter int PAK_BYTES = 32768,
    parameter int PORTS     = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [3:0]                    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // port[1:0], no_reply[2], pak_address[18:3], write_byte[26:19], zeros above
    input  logic [cpr_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // no_device[0], reply_byte[8:1], crc_valid[9], zeros above
    output logic [cpr_pkg::M_TDATA_W-1:0] m_tdata,
    // is_crc
    output logic                          m_tuser,
    output logic                          m_tlast
);

    cpr_pkg::cmd_t cmd;
    cpr_pkg::sts_t sts;

    cpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpr_datapath #(
        .PAK_BYTES (PAK_BYTES),
        .PORTS     (PORTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
